### hdl/double_ended_queue_defines.svh
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Concurrent checks that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF

`define DEQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("deque check failed");

`define DEQ_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("deque forbidden condition seen");

`else

`define DEQ_ASSERT(label, clk, rst_n, prop)

`define DEQ_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

### hdl/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Sizes, request and status codes, and the control word of the cell row.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int CAPACITY    = 16;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int DATA_W      = 32;
    localparam int ACTION_W    = 3;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic             shift_right;
        logic             shift_left;
        logic             push_back;
        logic [CNT_W-1:0] count;
    } t_cell_ctrl;

endpackage

### hdl/double_ended_queue.sv
// Double-ended queue of 32-bit signed entries held in a row of 16 cells, front
// entry in the first cell. Every request (push front, push back, pop front,
// pop back, clear) gives one response with the popped value, a status, the
// count after the request and an empty flag. One request is taken per clock;
// the response is in the output register from the cycle after acceptance, and
// a new request is taken while that register is free or being drained. Push
// front and pop front shift the whole cell row by one in the same cycle; pop
// back reads the last occupied cell through a selection over all cells, which
// sets the clock path. A push on a full queue is dropped with status full, a
// pop on an empty queue returns status empty, and neither changes the queue.
// ----------------------------------------------------------------------------
// Double-ended queue top level
// Request decode, entry count, cell row and response register.
// ----------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module double_ended_queue (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [deq_pkg::ACTION_W-1:0]           i_action,
    input  logic signed [deq_pkg::DATA_W-1:0]      i_push_value,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [deq_pkg::DATA_W-1:0]      o_pop_value,
    output logic [deq_pkg::STATUS_W-1:0]           o_status,
    output logic [deq_pkg::COUNT_OUT_W-1:0]        o_entry_count_out,
    output logic                                   o_is_empty
);
    import deq_pkg::*;

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_pop_value;
    logic signed [DATA_W-1:0] n_pop_value;
    logic [STATUS_W-1:0]      r_out_status;
    logic [STATUS_W-1:0]      n_status;
    logic [CNT_W-1:0]         r_out_count;
    logic                     r_out_empty;
    logic                     w_accept;
    logic                     w_full;
    logic                     w_empty;
    t_cell_ctrl               w_ctrl;
    logic signed [DATA_W-1:0] w_front_value;
    logic signed [DATA_W-1:0] w_back_value;

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_empty  = (r_count == '0);

    always_comb begin
        n_count            = r_count;
        n_pop_value        = '0;
        n_status           = ST_OK;
        w_ctrl.shift_right = 1'b0;
        w_ctrl.shift_left  = 1'b0;
        w_ctrl.push_back   = 1'b0;
        w_ctrl.count       = r_count;
        case (i_action)
            ACT_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.shift_right = w_accept;
                    n_count            = r_count + CNT_W'(1);
                end
            end
            ACT_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.push_back = w_accept;
                    n_count          = r_count + CNT_W'(1);
                end
            end
            ACT_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_pop_value       = w_front_value;
                    w_ctrl.shift_left = w_accept;
                    n_count           = r_count - CNT_W'(1);
                end
            end
            ACT_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_pop_value = w_back_value;
                    n_count     = r_count - CNT_W'(1);
                end
            end
            ACT_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    deq_chain u_chain (
        .i_clk         (i_clk),
        .i_ctrl        (w_ctrl),
        .i_push_value  (i_push_value),
        .o_front_value (w_front_value),
        .o_back_value  (w_back_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_pop_value <= n_pop_value;
            r_out_status    <= n_status;
            r_out_count     <= n_count;
            r_out_empty     <= (n_count == '0);
        end
    end

    assign o_valid           = r_out_valid;
    assign o_pop_value       = r_out_pop_value;
    assign o_status          = r_out_status;
    assign o_entry_count_out = COUNT_OUT_W'(r_out_count);
    assign o_is_empty        = r_out_empty;

    `DEQ_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CNT_W'(CAPACITY))
    `DEQ_ASSERT(a_full_drop, i_clk, i_rst_n, (w_accept && w_full && (i_action == ACT_PUSH_FRONT || i_action == ACT_PUSH_BACK)) |=> (r_out_status == ST_FULL && $stable(r_count)))
    `DEQ_ASSERT(a_clear_count, i_clk, i_rst_n, (w_accept && i_action == ACT_CLEAR) |=> (r_count == '0 && r_out_empty))
    `DEQ_ASSERT(a_resp_count, i_clk, i_rst_n, (w_accept) |=> (r_out_count == r_count))

endmodule

### hdl/deq_cell.sv
// ----------------------------------------------------------------------------
// Double-ended queue cell
// Holds one entry; takes a neighbor's entry on a shift or the pushed value
// when it is the slot just past the back.
// ----------------------------------------------------------------------------
module deq_cell (
    input  logic                             i_clk,
    input  logic [deq_pkg::IDX_W-1:0]        i_index,
    input  deq_pkg::t_cell_ctrl              i_ctrl,
    input  logic signed [deq_pkg::DATA_W-1:0] i_push_value,
    input  logic signed [deq_pkg::DATA_W-1:0] i_left,
    input  logic signed [deq_pkg::DATA_W-1:0] i_right,
    output logic signed [deq_pkg::DATA_W-1:0] o_value,
    output logic signed [deq_pkg::DATA_W-1:0] o_tap
);
    import deq_pkg::*;

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;
    logic [CNT_W-1:0]         w_pos;
    logic                     w_hit_back;
    logic                     w_hit_last;

    assign w_pos      = CNT_W'(i_index);
    assign w_hit_back = (w_pos == i_ctrl.count);
    assign w_hit_last = ((w_pos + CNT_W'(1)) == i_ctrl.count);

    always_comb begin
        n_value = r_value;
        if (i_ctrl.shift_right) begin
            n_value = i_left;
        end else if (i_ctrl.shift_left) begin
            n_value = i_right;
        end else if (i_ctrl.push_back && w_hit_back) begin
            n_value = i_push_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_tap   = w_hit_last ? r_value : '0;

endmodule

### hdl/deq_chain.sv
// ----------------------------------------------------------------------------
// Double-ended queue cell row
// A row of cells, front entry in the first cell, entries shifting together.
// ----------------------------------------------------------------------------
module deq_chain (
    input  logic                              i_clk,
    input  deq_pkg::t_cell_ctrl               i_ctrl,
    input  logic signed [deq_pkg::DATA_W-1:0] i_push_value,
    output logic signed [deq_pkg::DATA_W-1:0] o_front_value,
    output logic signed [deq_pkg::DATA_W-1:0] o_back_value
);
    import deq_pkg::*;

    logic signed [DATA_W-1:0] w_value [CAPACITY];
    logic signed [DATA_W-1:0] w_tap   [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_push_value;
        end else begin : g_mid_left
            assign w_left = w_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_value[g];
        end else begin : g_mid_right
            assign w_right = w_value[g+1];
        end

        deq_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (IDX_W'(g)),
            .i_ctrl       (i_ctrl),
            .i_push_value (i_push_value),
            .i_left       (w_left),
            .i_right      (w_right),
            .o_value      (w_value[g]),
            .o_tap        (w_tap[g])
        );
    end

    always_comb begin
        o_back_value = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            o_back_value = o_back_value | w_tap[k];
        end
    end

    assign o_front_value = w_value[0];

endmodule
